### rtl/core/sprite_batch_slot_binder_defines.svh
// assertion macros shared by the checker
`ifndef SPRITE_BATCH_SLOT_BINDER_DEFINES_SVH
`define SPRITE_BATCH_SLOT_BINDER_DEFINES_SVH

// same-cycle implication, clocked and reset-gated
`define SBSB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked and reset-gated
`define SBSB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sbsb_pkg.sv
package sbsb_pkg;

  typedef enum logic [1:0] {
    REQ_QUAD   = 2'd0,
    REQ_TRI    = 2'd1,
    REQ_FLUSH  = 2'd2,
    REQ_UNUSED = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_BIND,
    ST_SEARCH,
    ST_EMIT,
    ST_REPORT
  } state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] texture_id;
  } req_t;

  typedef struct packed {
    logic [3:0]  tex_slot;
    logic [15:0] index_value;
    logic        flush_before;
    logic [16:0] batch_vertices;
    logic [16:0] batch_indices;
    logic        last;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic check;
    logic bind_start;
    logic search;
    logic emit;
    logic report;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic white_hit;
    logic multi;
    logic hit;
    logic search_end;
    logic emit_last;
  } status_t;

  localparam logic [1:0] QUAD_OFFS [6] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd3, 2'd1};

  function automatic logic [1:0] index_offset(logic [1:0] req, logic [2:0] k);
    if (req == REQ_QUAD) begin
      return (k < 3'd6) ? QUAD_OFFS[k] : 2'd0;
    end
    return k[1:0];
  endfunction

  function automatic logic [2:0] shape_verts(logic [1:0] req);
    return (req == REQ_QUAD) ? 3'd4 : 3'd3;
  endfunction

  function automatic logic [2:0] shape_indices(logic [1:0] req);
    return (req == REQ_QUAD) ? 3'd6 : 3'd3;
  endfunction

endpackage

### rtl/core/sbsb_ctrl.sv
module sbsb_ctrl
  import sbsb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  logic [1:0] req_type_i,
  input  status_t   status_i,
  output cmd_t      cmd_o,
  output logic      busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.capture = 1'b1;
          if (req_type_i == REQ_QUAD || req_type_i == REQ_TRI) begin
            state_d = ST_CHECK;
          end else if (req_type_i == REQ_FLUSH) begin
            state_d = ST_REPORT;
          end
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = ST_BIND;
      end
      ST_BIND: begin
        cmd_o.bind_start = 1'b1;
        if (status_i.white_hit || !status_i.multi) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
        if (status_i.hit || status_i.search_end) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (status_i.emit_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_REPORT: begin
        cmd_o.report = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/sbsb_dpath.sv
module sbsb_dpath
  import sbsb_pkg::*;
#(
  parameter int TEXTURE_SLOTS   = 16,
  parameter int VERTEX_CAPACITY = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  req_t        req_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  output logic        result_valid_o,
  output res_t        result_o
);

  localparam int SW = $clog2(TEXTURE_SLOTS);
  localparam int UW = $clog2(TEXTURE_SLOTS + 1);

  logic [31:0]   white_q, white_d;
  logic [16:0]   vt_q, vt_d, it_q, it_d;
  logic [UW-1:0] used_q, used_d;
  logic          res_valid_q, res_valid_d;

  logic [1:0]    req_q, req_d;
  logic [31:0]   tex_q, tex_d;
  logic [16:0]   fv_q, fv_d, fi_q, fi_d;
  logic          flushed_q, flushed_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [SW-1:0] srch_q, srch_d;
  logic [2:0]    k_q, k_d;
  res_t          res_q, res_d;

  logic [31:0]   slot_ids_q [TEXTURE_SLOTS];
  logic [31:0]   rd_q;
  logic          mem_we;

  logic          need_flush, new_ok, bind_now;
  logic [SW-1:0] new_slot;
  logic [31:0]   slot_wide;
  logic [1:0]    off;

  assign status_o.white_hit  = (tex_q == white_q);
  assign status_o.multi      = (used_q > UW'(1));
  assign status_o.hit        = (rd_q == tex_q);
  assign status_o.search_end = ((UW'(srch_q) + UW'(1)) >= used_q);
  assign status_o.emit_last  = (k_q == shape_indices(req_q) - 3'd1);

  assign need_flush = (used_q >= UW'(TEXTURE_SLOTS)) ||
                      ((18'(vt_q) + 18'(shape_verts(req_q))) > 18'(VERTEX_CAPACITY));
  assign new_ok     = (used_q < UW'(TEXTURE_SLOTS));
  assign new_slot   = used_q[SW-1:0];
  assign bind_now   = (cmd_i.bind_start && !status_o.white_hit && !status_o.multi) ||
                      (cmd_i.search && !status_o.hit && status_o.search_end);
  assign slot_wide  = 32'(slot_q);
  assign off        = index_offset(req_q, k_q);

  always_comb begin
    white_d     = cfg_we_i ? cfg_wdata_i : white_q;
    vt_d        = vt_q;
    it_d        = it_q;
    used_d      = used_q;
    res_valid_d = 1'b0;
    req_d       = req_q;
    tex_d       = tex_q;
    fv_d        = fv_q;
    fi_d        = fi_q;
    flushed_d   = flushed_q;
    slot_d      = slot_q;
    srch_d      = srch_q;
    k_d         = k_q;
    res_d       = res_q;
    mem_we      = 1'b0;

    if (cmd_i.capture) begin
      req_d = req_i.req_type;
      tex_d = req_i.texture_id;
    end

    if (cmd_i.check) begin
      k_d = 3'd0;
      if (need_flush) begin
        fv_d      = vt_q;
        fi_d      = it_q;
        flushed_d = 1'b1;
        if (it_q != 17'd0) begin
          vt_d   = '0;
          it_d   = '0;
          used_d = UW'(1);
        end
      end else begin
        fv_d      = '0;
        fi_d      = '0;
        flushed_d = 1'b0;
      end
    end

    if (cmd_i.bind_start) begin
      if (status_o.white_hit) begin
        slot_d = '0;
      end else if (status_o.multi) begin
        srch_d = SW'(1);
      end
    end

    if (cmd_i.search) begin
      if (status_o.hit) begin
        slot_d = srch_q;
      end else if (!status_o.search_end) begin
        srch_d = srch_q + SW'(1);
      end
    end

    // bind to the next free slot, or to slot zero when the table is full
    if (bind_now) begin
      if (new_ok) begin
        mem_we = 1'b1;
        slot_d = new_slot;
        used_d = used_q + UW'(1);
      end else begin
        slot_d = '0;
      end
    end

    if (cmd_i.emit) begin
      res_valid_d          = 1'b1;
      res_d.tex_slot       = slot_wide[3:0];
      res_d.index_value    = 16'(vt_q + 17'(off));
      res_d.flush_before   = flushed_q;
      res_d.batch_vertices = fv_q;
      res_d.batch_indices  = fi_q;
      res_d.last           = status_o.emit_last;
      k_d                  = k_q + 3'd1;
      if (status_o.emit_last) begin
        vt_d = vt_q + 17'(shape_verts(req_q));
        it_d = it_q + 17'(shape_indices(req_q));
      end
    end

    if (cmd_i.report) begin
      res_valid_d          = 1'b1;
      res_d.tex_slot       = '0;
      res_d.index_value    = '0;
      res_d.flush_before   = 1'b0;
      res_d.batch_vertices = vt_q;
      res_d.batch_indices  = it_q;
      res_d.last           = 1'b1;
      if (it_q != 17'd0) begin
        vt_d   = '0;
        it_d   = '0;
        used_d = UW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_q     <= '0;
      vt_q        <= '0;
      it_q        <= '0;
      used_q      <= UW'(1);
      res_valid_q <= 1'b0;
    end else begin
      white_q     <= white_d;
      vt_q        <= vt_d;
      it_q        <= it_d;
      used_q      <= used_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    tex_q     <= tex_d;
    fv_q      <= fv_d;
    fi_q      <= fi_d;
    flushed_q <= flushed_d;
    slot_q    <= slot_d;
    srch_q    <= srch_d;
    k_q       <= k_d;
    res_q     <= res_d;
  end

  // slot table, registered read follows the search pointer
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_ids_q[new_slot] <= tex_q;
    end
    rd_q <= slot_ids_q[srch_d];
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

### rtl/core/sprite_batch_slot_binder.sv
// channel   | handshake              | payload
// ----------+------------------------+------------------------
// request   | start / busy           | req_i (req_t)
// result    | result_valid_o strobe  | result_o (res_t)
// config    | cfg_we_i               | cfg_wdata_i (white id)
//
// a request is taken when start is high and busy is low
// draw: accept, check, bind, a search of the bound table entries unless the white
//   id hits (one table entry per cycle through the registered read port), then
//   6 or 3 results; no new request is taken before the last result
// flush request: one result; unused request code: no result
// results are registered and strobed once; the receiver cannot stall them
// reset is asynchronous active low; the slot table itself is never cleared
module sprite_batch_slot_binder
  import sbsb_pkg::*;
#(
  parameter int TEXTURE_SLOTS   = 16,
  parameter int VERTEX_CAPACITY = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  req_t        req_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        result_valid_o,
  output res_t        result_o
);

  cmd_t    cmd;
  status_t status;

  // sequencer: request decode, slot search walk, index emission
  sbsb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_type_i (req_i.req_type),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  // batch counters, slot table, white id register and result register
  sbsb_dpath #(
    .TEXTURE_SLOTS   (TEXTURE_SLOTS),
    .VERTEX_CAPACITY (VERTEX_CAPACITY)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

### rtl/core/sbsb_checker.sv
`include "sprite_batch_slot_binder_defines.svh"

module sbsb_checker
  import sbsb_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic result_valid_o,
  input res_t result_o
);

  logic take_flush, take_unused;

  assign take_flush  = start && !busy && (req_i.req_type == REQ_FLUSH);
  assign take_unused = start && !busy && (req_i.req_type == REQ_UNUSED);

  // a flush request keeps the block busy for its report cycle
  `SBSB_ASSERT_NXT(a_flush_busy, clk_i, rst_ni, take_flush, busy, "flush not busy")
  // the unused request code is dropped at once
  `SBSB_ASSERT_NXT(a_unused_idle, clk_i, rst_ni, take_unused, !busy, "unused code stalled")
  // results of one request come back to back
  `SBSB_ASSERT_NXT(a_burst, clk_i, rst_ni, result_valid_o && !result_o.last,
                   result_valid_o, "gap inside result burst")
  // the final result closes the burst
  `SBSB_ASSERT_NXT(a_last_gap, clk_i, rst_ni, result_valid_o && result_o.last,
                   !result_valid_o, "result after last")

endmodule

bind sprite_batch_slot_binder sbsb_checker u_sbsb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .req_i          (req_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

### tb/testbench.sv
module testbench;
  import sbsb_pkg::*;

  // block sizing, matched to the instance below
  localparam int TEX_SLOTS    = 16;
  localparam int VTX_CAPACITY = 65536;
  localparam int POOL_SIZE    = 24;

  // corner order of the two triangles of a quad
  localparam int unsigned QUAD_CORNER [6] = '{0, 1, 2, 0, 3, 1};

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  req_t        req = '0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        result_valid;
  res_t        result;

  // texture ids reused often so that lookups hit and the table fills
  logic [31:0] tex_pool [POOL_SIZE];

  always #6 clk = ~clk;

  sprite_batch_slot_binder #(
    .TEXTURE_SLOTS  (TEX_SLOTS),
    .VERTEX_CAPACITY(VTX_CAPACITY)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .result_valid_o(result_valid),
    .result_o      (result)
  );

  // tracks the batch and slot table, and holds the index results still due
  class batch_scoreboard;
    logic [31:0] white_id;
    logic [31:0] slot_tex [TEX_SLOTS];
    int unsigned slots_used;
    int unsigned vertex_total;
    int unsigned index_total;
    res_t        due [$];
    int          errors;

    function new();
      white_id     = '0;
      slots_used   = 1;
      vertex_total = 0;
      index_total  = 0;
      errors       = 0;
    endfunction

    // append one expected result at the tail
    function void add_due(res_t e);
      due.insert(due.size(), e);
    endfunction

    // report counts; only a non-empty batch is cleared
    function void close_batch(output logic [16:0] verts, output logic [16:0] idx);
      verts = 17'(vertex_total);
      idx   = 17'(index_total);
      if (index_total != 0) begin
        vertex_total = 0;
        index_total  = 0;
        slots_used   = 1;
      end
    endfunction

    // white id wins, then the lowest bound slot, else the next free one
    function int unsigned find_slot(logic [31:0] tex);
      int unsigned i;
      if (tex == white_id) begin
        return 0;
      end
      for (i = 1; i < slots_used; i++) begin
        if (slot_tex[i] == tex) begin
          return i;
        end
      end
      slot_tex[slots_used] = tex;
      slots_used++;
      return slots_used - 1;
    endfunction

    function void note_request(req_t r);
      logic [16:0] fv;
      logic [16:0] fi;
      logic        flushed;
      int unsigned verts;
      int unsigned count;
      int unsigned slot;
      int unsigned base;
      int unsigned offs;
      res_t        e;
      fv      = '0;
      fi      = '0;
      flushed = 1'b0;
      e       = '0;
      case (r.req_type)
        REQ_QUAD: begin
          verts = 4;
          count = 6;
        end
        REQ_TRI: begin
          verts = 3;
          count = 3;
        end
        REQ_FLUSH: begin
          close_batch(fv, fi);
          e.batch_vertices = fv;
          e.batch_indices  = fi;
          e.last           = 1'b1;
          add_due(e);
          return;
        end
        default: begin
          return;
        end
      endcase
      // full slot table or vertex overflow closes the batch first
      if (slots_used >= TEX_SLOTS || vertex_total + verts > VTX_CAPACITY) begin
        close_batch(fv, fi);
        flushed = 1'b1;
      end
      slot = find_slot(r.texture_id);
      base = vertex_total;
      for (int unsigned k = 0; k < count; k++) begin
        offs             = (r.req_type == REQ_QUAD) ? QUAD_CORNER[k] : k;
        e.tex_slot       = 4'(slot);
        e.index_value    = 16'(base + offs);
        e.flush_before   = flushed;
        e.batch_vertices = fv;
        e.batch_indices  = fi;
        e.last           = (k == count - 1);
        add_due(e);
      end
      vertex_total = (vertex_total + verts) & 32'h1FFFF;
      index_total  = (index_total + count) & 32'h1FFFF;
    endfunction

    function void report(string field, logic [31:0] want, logic [31:0] seen);
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, seen);
      errors++;
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (due.size() == 0) begin
        $display("%0t: result with nothing pending: expected none, got %p", $time, got);
        errors++;
        return;
      end
      e = due.pop_front();
      if (got.tex_slot !== e.tex_slot) begin
        report("tex_slot", 32'(e.tex_slot), 32'(got.tex_slot));
      end
      if (got.index_value !== e.index_value) begin
        report("index_value", 32'(e.index_value), 32'(got.index_value));
      end
      if (got.flush_before !== e.flush_before) begin
        report("flush_before", 32'(e.flush_before), 32'(got.flush_before));
      end
      if (got.batch_vertices !== e.batch_vertices) begin
        report("batch_vertices", 32'(e.batch_vertices), 32'(got.batch_vertices));
      end
      if (got.batch_indices !== e.batch_indices) begin
        report("batch_indices", 32'(e.batch_indices), 32'(got.batch_indices));
      end
      if (got.last !== e.last) begin
        report("last", 32'(e.last), 32'(got.last));
      end
    endfunction
  endclass

  batch_scoreboard sb = new();

  // every strobed result is checked at the edge that ends its cycle
  always @(posedge clk) begin
    if (rst_ni && result_valid) begin
      sb.check_result(result);
    end
  end

  function automatic req_t make_req(logic [1:0] kind, logic [31:0] tex);
    req_t r;
    r.req_type   = kind;
    r.texture_id = tex;
    return r;
  endfunction

  // mostly draws, some flushes, a few ignored codes
  function automatic req_t pick_request();
    req_t        r;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 42) begin
      r.req_type = REQ_QUAD;
    end else if (roll < 84) begin
      r.req_type = REQ_TRI;
    end else if (roll < 94) begin
      r.req_type = REQ_FLUSH;
    end else begin
      r.req_type = REQ_UNUSED;
    end
    // white id, a pooled id, or a fresh random one
    roll = $urandom_range(0, 3);
    if (roll == 0) begin
      r.texture_id = sb.white_id;
    end else if (roll == 3) begin
      r.texture_id = $urandom();
    end else begin
      r.texture_id = tex_pool[$urandom_range(0, POOL_SIZE - 1)];
    end
    return r;
  endfunction

  // present one request and hold it until the block takes it;
  // start stays high so a following request goes out back to back
  task automatic send(req_t r);
    start <= 1'b1;
    req   <= r;
    do begin
      @(posedge clk);
    end while (busy);
    sb.note_request(r);
  endtask

  task automatic hold_off(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // sender pauses until every result is in and the block is idle;
  // a few extra cycles cover an ignored request still in flight
  task automatic wait_for_quiet();
    start <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic write_white(logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    sb.white_id = value;
  endtask

  task automatic run_random(int count, bit with_idle, int drain_every);
    for (int i = 0; i < count; i++) begin
      send(pick_request());
      if (with_idle && $urandom_range(0, 3) == 0) begin
        hold_off($urandom_range(1, 13));
      end
      if (drain_every != 0 && (i + 1) % drain_every == 0) begin
        wait_for_quiet();
      end
    end
  endtask

  initial begin
    tex_pool[0] = 32'h0000_0000;
    tex_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) begin
      tex_pool[i] = $urandom();
    end

    repeat (5) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // directed: flush of an empty batch leaves it alone
    send(make_req(REQ_FLUSH, 32'hFFFF_FFFF));
    // white texture at reset value lands in slot zero
    send(make_req(REQ_QUAD, 32'h0000_0000));
    send(make_req(REQ_TRI, 32'hFFFF_FFFF));
    send(make_req(REQ_QUAD, 32'h1234_5678));
    hold_off(3);
    // already bound id is found again
    send(make_req(REQ_TRI, 32'hFFFF_FFFF));
    // ignored code, no result
    send(make_req(REQ_UNUSED, 32'h0000_0000));
    send(make_req(REQ_FLUSH, 32'h0000_0000));
    send(make_req(REQ_FLUSH, 32'h0000_0000));
    // fill every slot, then one more draw forces a flush first;
    // its id is stale in the table but must be bound afresh
    for (int i = 1; i < TEX_SLOTS; i++) begin
      send(make_req((i % 2) ? REQ_QUAD : REQ_TRI, 32'h0000_1000 + i));
    end
    send(make_req(REQ_TRI, 32'h0000_1003));
    wait_for_quiet();

    // all-ones white id, random traffic with gaps and periodic drains
    write_white(32'hFFFF_FFFF);
    run_random(150, 1'b1, 40);
    wait_for_quiet();

    // zero white id with the batch left open
    write_white(32'h0000_0000);
    run_random(150, 1'b1, 50);
    wait_for_quiet();

    // white id likely already bound in a slot, then gapless traffic
    write_white(tex_pool[$urandom_range(2, POOL_SIZE - 1)]);
    run_random(130, 1'b0, 0);

    // drain with a bound, then give stray results a chance to show
    start <= 1'b0;
    for (int n = 0; n < 4000 && sb.due.size() != 0; n++) @(posedge clk);
    repeat (16) @(posedge clk);

    if (sb.errors == 0 && sb.due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin
    #24000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
